// ----- hdl/epsp_pkg.sv -----
// Shared constants, types and the gain table builder for the stereo panner.
`default_nettype none

package epsp_pkg;

	localparam int POS_BITS      = 17;
	localparam int GAIN_BITS     = 16;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 17;

	localparam logic [POS_BITS-1:0] POS_ONE  = 17'h10000;
	localparam logic [POS_BITS-1:0] POS_HALF = 17'h08000;
	localparam logic [POS_BITS-1:0] POS_RESET = 17'h08000;

	// cos(pi/4) in Q1.15
	localparam logic signed [GAIN_BITS:0] CENTRE_GAIN = 17'sd23170;

	// pi/2 in Q60
	localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1847;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_STEREO_MODE = 2'd0,
		REG_POS_SOURCE  = 2'd1,
		REG_FIXED_POS   = 2'd2
	} cfg_reg_t;

	// per-item mixing control, travels with the data
	typedef struct packed {
		logic stereo;
		logic below;
	} mix_ctrl_t;

	// load enables of the two mixing stages
	typedef struct packed {
		logic s3;
		logic s4;
	} mix_en_t;

	// floor(a*b / 2^60)
	function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] ah;
		logic [63:0] al;
		logic [63:0] bh;
		logic [63:0] bl;
		logic [63:0] lo;
		logic [63:0] mid;
		begin
			ah  = a >> 32;
			al  = {32'd0, a[31:0]};
			bh  = b >> 32;
			bl  = {32'd0, b[31:0]};
			lo  = al * bl;
			mid = ah * bl + al * bh + (lo >> 32);
			return ((ah * bh) << 4) + (mid >> 28);
		end
	endfunction

	// floor(num / den) by shift and subtract, den non-zero; table build only
	function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] quo;
		logic [64:0] rem;
		begin
			quo = '0;
			rem = '0;
			for (int b = 63; b >= 0; b--) begin
				rem = {rem[63:0], num[b]};
				if (rem >= {1'b0, den}) begin
					rem    = rem - {1'b0, den};
					quo[b] = 1'b1;
				end
			end
			return quo;
		end
	endfunction

	// Taylor series sine, Q60 in and out, angle 0..pi/2
	function automatic logic [63:0] sin_q60(input logic [63:0] x);
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] dv;
		begin
			x2   = mul_q60(x, x);
			term = x;
			sum  = x;
			for (int n = 1; n <= 13; n++) begin
				dv   = 64'((2 * n) * (2 * n + 1));
				term = div_u64(mul_q60(term, x2), dv);
				if ((n & 1) == 1) begin
					sum = sum - term;
				end else begin
					sum = sum + term;
				end
			end
			return sum;
		end
	endfunction

	// Q1.15 gain for a Q60 angle, rounded, capped at 1.0
	function automatic logic [GAIN_BITS-1:0] gain_entry(input logic [63:0] ang);
		logic [63:0] s;
		logic [63:0] g;
		begin
			s = sin_q60(ang);
			g = (s + (64'd1 << 44)) >> 45;
			if (g > 64'd32768) begin
				g = 64'd32768;
			end
			return g[GAIN_BITS-1:0];
		end
	endfunction

endpackage

`default_nettype wire

// ----- hdl/epsp_ifs.sv -----
// Stream and configuration channel interfaces of the stereo panner.
`default_nettype none

interface epsp_in_if #(
	parameter int SAMPLE_BITS = 16
);
	import epsp_pkg::*;

	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] left_in;
	logic signed [SAMPLE_BITS-1:0] right_in;
	logic [POS_BITS-1:0]           pos_in;

	modport source (output valid, output left_in, output right_in, output pos_in, input ready);
	modport sink (input valid, input left_in, input right_in, input pos_in, output ready);
endinterface

interface epsp_out_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] left_out;
	logic signed [SAMPLE_BITS-1:0] right_out;

	modport source (output valid, output left_out, output right_out, input ready);
	modport sink (input valid, input left_out, input right_out, output ready);
endinterface

interface epsp_cfg_if;
	import epsp_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [CFG_IDX_BITS-1:0]  index;
	logic [CFG_DATA_BITS-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/epsp_gain_rom.sv -----
// Quarter-wave gain table with two registered read ports (right and left gain).
`default_nettype none

module epsp_gain_rom #(
	parameter int QUARTER_TABLE_ENTRIES = 1024,
	parameter int IDX_W = $clog2(QUARTER_TABLE_ENTRIES + 1)
) (
	input  wire logic                             clk,
	input  wire logic                             en,
	input  wire logic [IDX_W-1:0]                 idx,
	output logic      [epsp_pkg::GAIN_BITS-1:0]   lg_s2,
	output logic      [epsp_pkg::GAIN_BITS-1:0]   rg_s2
);
	import epsp_pkg::*;

	localparam logic [63:0] ANG_Q = HALF_PI_Q60 / QUARTER_TABLE_ENTRIES;
	localparam logic [63:0] ANG_R = HALF_PI_Q60 % QUARTER_TABLE_ENTRIES;

	logic [GAIN_BITS-1:0] rom_w [QUARTER_TABLE_ENTRIES+1];
	logic [IDX_W-1:0]     idx_left;

	// entry k = round(32768 * sin(k*pi/(2N)))
	for (genvar k = 0; k <= QUARTER_TABLE_ENTRIES; k++) begin : g_rom
		localparam logic [63:0] ANG = ANG_Q * 64'(k) + (ANG_R * 64'(k)) / QUARTER_TABLE_ENTRIES;
		localparam logic [GAIN_BITS-1:0] GAIN = gain_entry(ANG);
		assign rom_w[k] = GAIN;
	end

	assign idx_left = IDX_W'(QUARTER_TABLE_ENTRIES) - idx;

	always_ff @(posedge clk) begin
		if (en) begin
			rg_s2 <= rom_w[idx];
			lg_s2 <= rom_w[idx_left];
		end
	end

endmodule

`default_nettype wire

// ----- hdl/epsp_mix.sv -----
// Gain multiply stage and sum / round / saturate stage.
`default_nettype none

module epsp_mix #(
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic                                clk,
	input  wire epsp_pkg::mix_en_t                   en,
	input  wire epsp_pkg::mix_ctrl_t                 ctrl_s2,
	input  wire logic signed [SAMPLE_BITS-1:0]       l_s2,
	input  wire logic signed [SAMPLE_BITS-1:0]       r_s2,
	input  wire logic        [epsp_pkg::GAIN_BITS-1:0] lg_s2,
	input  wire logic        [epsp_pkg::GAIN_BITS-1:0] rg_s2,
	output logic signed      [SAMPLE_BITS-1:0]       left_s4,
	output logic signed      [SAMPLE_BITS-1:0]       right_s4
);
	import epsp_pkg::*;

	localparam int PROD_W = SAMPLE_BITS + GAIN_BITS + 1;
	localparam int ACC_W  = PROD_W + 1;
	localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(16384);
	localparam logic signed [ACC_W-1:0] SMAX = (ACC_W'(1) << (SAMPLE_BITS - 1)) - ACC_W'(1);
	localparam logic signed [ACC_W-1:0] SMIN = -SMAX - ACC_W'(1);

	logic signed [GAIN_BITS:0]       lg_sx;
	logic signed [GAIN_BITS:0]       rg_sx;
	logic signed [GAIN_BITS:0]       xgain;
	logic signed [SAMPLE_BITS-1:0]   xsamp;
	logic signed [PROD_W-1:0]        pl;
	logic signed [PROD_W-1:0]        pr;
	logic signed [PROD_W-1:0]        px;

	logic signed [PROD_W-1:0]        pl_s3;
	logic signed [PROD_W-1:0]        pr_s3;
	logic signed [PROD_W-1:0]        px_s3;
	logic                            below_s3;

	logic signed [ACC_W-1:0]         acc_l;
	logic signed [ACC_W-1:0]         acc_r;

	function automatic logic signed [SAMPLE_BITS-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W-1:0] sh;
		logic signed [ACC_W-1:0] res;
		begin
			sh = (acc + ROUND_HALF) >>> 15;
			if (sh > SMAX) begin
				res = SMAX;
			end else if (sh < SMIN) begin
				res = SMIN;
			end else begin
				res = sh;
			end
			return res[SAMPLE_BITS-1:0];
		end
	endfunction

	// stage 3: own-gain products plus, in stereo mode, the cross-mix product of the stronger side
	always_comb begin
		lg_sx = $signed({1'b0, lg_s2});
		rg_sx = $signed({1'b0, rg_s2});
		xgain = ctrl_s2.below ? (lg_sx - CENTRE_GAIN) : (rg_sx - CENTRE_GAIN);
		xsamp = ctrl_s2.below ? r_s2 : l_s2;
		pl    = l_s2 * lg_sx;
		pr    = r_s2 * rg_sx;
		// kept out of a ?: so the product stays signed
		if (ctrl_s2.stereo) begin
			px = xsamp * xgain;
		end else begin
			px = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			pl_s3    <= pl;
			pr_s3    <= pr;
			px_s3    <= px;
			below_s3 <= ctrl_s2.below;
		end
	end

	// stage 4: cross term goes to the left below centre, else to the right
	always_comb begin
		acc_l = ACC_W'(pl_s3) + (below_s3 ? ACC_W'(px_s3) : '0);
		acc_r = ACC_W'(pr_s3) + (below_s3 ? '0 : ACC_W'(px_s3));
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			left_s4  <= round_sat(acc_l);
			right_s4 <= round_sat(acc_r);
		end
	end

endmodule

`default_nettype wire

// ----- hdl/equal_power_stereo_panner.sv -----
// Top level of the equal-power stereo panner: config registers, position stage, pipeline control.
//
//  channel  | dir | payload                          | handshake
//  ---------+-----+----------------------------------+-------------
//  in_ch    | in  | left_in, right_in, pos_in        | valid/ready
//  out_ch   | out | left_out, right_out              | valid/ready
//  cfg_ch   | in  | index, data                      | valid/ready
//
// One stereo frame per cycle while the output is not stalled; the stages in order are
// position/index, table read, multiply and round/saturate. The gain table read is the second stage.
// Each stage holds only while its successor is full and stalled, so bubbles close up.
// Reset clears the valid bits and loads the registers with centre position, regular mode.
// Config writes are always taken.
`default_nettype none

module equal_power_stereo_panner #(
	parameter int SAMPLE_BITS = 16,
	parameter int QUARTER_TABLE_ENTRIES = 1024
) (
	input  wire logic clk,
	input  wire logic arst_n,
	epsp_in_if.sink   in_ch,
	epsp_out_if.source out_ch,
	epsp_cfg_if.sink  cfg_ch
);
	import epsp_pkg::*;

	localparam int IDX_W = $clog2(QUARTER_TABLE_ENTRIES + 1);
	localparam int SCL_W = POS_BITS + IDX_W;

	logic                 stereo_mode_q;
	logic                 pos_source_q;
	logic [POS_BITS-1:0]  fixed_pos_q;

	logic v1_s1, v2_s2, v3_s3, v4_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	logic [POS_BITS-1:0]  pos_sel;
	logic [POS_BITS-1:0]  pos_c;
	logic [SCL_W-1:0]     pos_scaled;
	logic [IDX_W-1:0]     idx_raw;
	logic [IDX_W-1:0]     idx;

	logic [IDX_W-1:0]              idx_s1;
	logic signed [SAMPLE_BITS-1:0] l_s1;
	logic signed [SAMPLE_BITS-1:0] r_s1;
	mix_ctrl_t                     ctrl_s1;
	logic signed [SAMPLE_BITS-1:0] l_s2;
	logic signed [SAMPLE_BITS-1:0] r_s2;
	mix_ctrl_t                     ctrl_s2;
	logic [GAIN_BITS-1:0]          lg_s2;
	logic [GAIN_BITS-1:0]          rg_s2;
	mix_en_t                       mix_en;

	// configuration registers
	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stereo_mode_q <= 1'b0;
			pos_source_q  <= 1'b0;
			fixed_pos_q   <= POS_RESET;
		end else if (cfg_ch.valid) begin
			case (cfg_ch.index)
				REG_STEREO_MODE: stereo_mode_q <= cfg_ch.data[0];
				REG_POS_SOURCE:  pos_source_q  <= cfg_ch.data[0];
				REG_FIXED_POS:   fixed_pos_q   <= cfg_ch.data[POS_BITS-1:0];
				default: ;
			endcase
		end
	end

	// ready chain: a stage loads when it is empty or its contents move on
	assign rdy4        = !v4_s4 || out_ch.ready;
	assign rdy3        = !v3_s3 || rdy4;
	assign rdy2        = !v2_s2 || rdy3;
	assign rdy1        = !v1_s1 || rdy2;
	assign in_ch.ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
		end else begin
			if (rdy1) v1_s1 <= in_ch.valid;
			if (rdy2) v2_s2 <= v1_s1;
			if (rdy3) v3_s3 <= v2_s2;
			if (rdy4) v4_s4 <= v3_s3;
		end
	end

	// stage 1: pick and clamp the position, map it to a table index
	always_comb begin
		pos_sel    = pos_source_q ? in_ch.pos_in : fixed_pos_q;
		pos_c      = (pos_sel > POS_ONE) ? POS_ONE : pos_sel;
		pos_scaled = SCL_W'(pos_c) * SCL_W'(QUARTER_TABLE_ENTRIES) + SCL_W'(POS_HALF);
		idx_raw    = pos_scaled[16 +: IDX_W];
		idx        = (idx_raw > IDX_W'(QUARTER_TABLE_ENTRIES)) ?
		             IDX_W'(QUARTER_TABLE_ENTRIES) : idx_raw;
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			idx_s1         <= idx;
			l_s1           <= in_ch.left_in;
			r_s1           <= in_ch.right_in;
			ctrl_s1.stereo <= stereo_mode_q;
			ctrl_s1.below  <= (pos_c < POS_HALF);
		end
	end

	// stage 2: table read alongside the samples
	always_ff @(posedge clk) begin
		if (rdy2) begin
			l_s2    <= l_s1;
			r_s2    <= r_s1;
			ctrl_s2 <= ctrl_s1;
		end
	end

	epsp_gain_rom #(
		.QUARTER_TABLE_ENTRIES(QUARTER_TABLE_ENTRIES),
		.IDX_W(IDX_W)
	) u_gain_rom (
		.clk  (clk),
		.en   (rdy2),
		.idx  (idx_s1),
		.lg_s2(lg_s2),
		.rg_s2(rg_s2)
	);

	assign mix_en.s3 = rdy3;
	assign mix_en.s4 = rdy4;

	epsp_mix #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_mix (
		.clk     (clk),
		.en      (mix_en),
		.ctrl_s2 (ctrl_s2),
		.l_s2    (l_s2),
		.r_s2    (r_s2),
		.lg_s2   (lg_s2),
		.rg_s2   (rg_s2),
		.left_s4 (out_ch.left_out),
		.right_s4(out_ch.right_out)
	);

	assign out_ch.valid = v4_s4;

endmodule

`default_nettype wire

// ----- hdl/epsp_checker.sv -----
// Port-level checks of the stereo panner, bound to the top level.
`default_nettype none

module epsp_checker #(
	parameter int SAMPLE_BITS = 16
) (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   in_valid,
	input wire logic                   in_ready,
	input wire logic                   out_valid,
	input wire logic                   out_ready,
	input wire logic [SAMPLE_BITS-1:0] left_out,
	input wire logic [SAMPLE_BITS-1:0] right_out
);

	logic       in_acc;
	logic       out_acc;
	logic [2:0] inflight_q;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= 3'd0;
		end else if (in_acc && !out_acc) begin
			inflight_q <= inflight_q + 3'd1;
		end else if (out_acc && !in_acc) begin
			inflight_q <= inflight_q - 3'd1;
		end
	end

	// a stalled result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(left_out) && $stable(right_out))
		else $error("result changed while stalled");

	// input back-pressure only when the output is full and stalled
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled with output free");

	// at most four requests inside the pipeline
	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= 3'd4)
		else $error("more requests in flight than stages");

	// no result without a pending request
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> inflight_q != 3'd0)
		else $error("result with nothing in flight");

endmodule

bind equal_power_stereo_panner epsp_checker #(
	.SAMPLE_BITS(SAMPLE_BITS)
) u_epsp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_ch.valid),
	.in_ready (in_ch.ready),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.left_out (out_ch.left_out),
	.right_out(out_ch.right_out)
);

`default_nettype wire
